@@ src/ttpr_pkg.sv @@
// Package for the text tilemap pixel renderer.
// Operation codes, register indexes and the fade/blend helper. No dependencies.
package ttpr_pkg;
  localparam logic [1:0] OP_RENDER = 2'd0;
  localparam logic [1:0] OP_CHAR   = 2'd1;
  localparam logic [1:0] OP_PAL    = 2'd2;
  localparam logic [1:0] OP_GAMMA  = 2'd3;

  localparam logic [2:0] REG_SCROLL_X = 3'd0;
  localparam logic [2:0] REG_SCROLL_Y = 3'd1;
  localparam logic [2:0] REG_PAL_BASE = 3'd2;
  localparam logic [2:0] REG_FADE_F   = 3'd3;
  localparam logic [2:0] REG_FADE_C   = 3'd4;
  localparam logic [2:0] REG_ALPHA    = 3'd5;
  localparam logic [2:0] REG_MODE     = 3'd6;
  localparam logic [2:0] REG_BG       = 3'd7;

  localparam int PLANE_BYTES = 32768;
  localparam int GAMMA_BYTES = 768;

  typedef logic [7:0] byte_t;
  typedef byte_t [2:0] rgb_t;

  // weighted sum, 16 bits; divide by 255 done separately
  function automatic logic [15:0] mix_sum(input byte_t c, input byte_t t, input byte_t f);
    logic [15:0] a;
    logic [15:0] b;
    a = 16'(c) * 16'(8'hFF - f);
    b = 16'(t) * 16'(f);
    return a + b;
  endfunction

  // s/255 for s <= 65025 via reciprocal and one correction
  function automatic byte_t div255(input logic [15:0] s);
    logic [16:0] q;
    logic [16:0] r;
    q = 17'((s + 16'd1 + {8'd0, s[15:8]}) >> 8);
    r = 17'(s) - 17'(q * 17'd255);
    if (r[16]) q = q - 17'd1;
    return q[7:0];
  endfunction
endpackage

@@ src/text_tilemap_pixel_renderer.sv @@
// Top level of the text tilemap pixel renderer.
// Throughput is one beat per cycle while the input is not stalled.
// The chain of memory reads (map, character, palette, gamma) sets the stage count.
// Memories are undefined until written; rst clears registers and the pipeline valids.
// Output holds in a 16-entry queue; input stalls when queued plus in-flight beats reach 15.
module text_tilemap_pixel_renderer #(
  parameter int CHAR_RAM_BYTES = 131072,
  parameter int SCREEN_WIDTH = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [27:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[1:0] address[18:2] write_data[26:19] pixel_x[36:27] pixel_y[45:37]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // red[7:0] green[15:8] blue[23:16] alpha[31:24]
  output logic [31:0] m_tdata
);
  import ttpr_pkg::*;
  localparam int CAW = $clog2(CHAR_RAM_BYTES);

  logic [15:0] scroll_x_word, scroll_y_word;
  logic [7:0] palette_base, fade_factor;
  logic [23:0] fade_colour, background_colour;
  logic [27:0] alpha_control;
  logic [2:0] mode_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x_word <= '0; scroll_y_word <= '0; palette_base <= '0;
      fade_factor <= '0; fade_colour <= '0; alpha_control <= '0;
      mode_flags <= '0; background_colour <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCROLL_X: scroll_x_word <= cfg_data[15:0];
        REG_SCROLL_Y: scroll_y_word <= cfg_data[15:0];
        REG_PAL_BASE: palette_base <= cfg_data[7:0];
        REG_FADE_F:   fade_factor <= cfg_data[7:0];
        REG_FADE_C:   fade_colour <= cfg_data[23:0];
        REG_ALPHA:    alpha_control <= cfg_data;
        REG_MODE:     mode_flags <= cfg_data[2:0];
        REG_BG:       background_colour <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic [1:0] in_op;
  logic [16:0] in_addr;
  logic [7:0] in_data;
  logic [9:0] in_px;
  logic [8:0] in_py;
  assign in_op = s_tdata[1:0];
  assign in_addr = s_tdata[18:2];
  assign in_data = s_tdata[26:19];
  assign in_px = s_tdata[36:27];
  assign in_py = s_tdata[45:37];

  logic acc;
  assign acc = s_tvalid && s_tready;

  // memories: char RAM as even/odd byte banks so both bytes of a tile word are read together
  logic [7:0] cram_e [CHAR_RAM_BYTES/2];
  logic [7:0] cram_o [CHAR_RAM_BYTES/2];
  logic [7:0] pal_r [PLANE_BYTES];
  logic [7:0] pal_g [PLANE_BYTES];
  logic [7:0] pal_b [PLANE_BYTES];
  logic [7:0] gam_r [256];
  logic [7:0] gam_g [256];
  logic [7:0] gam_b [256];

  // write delay line: each store is written at the stage where renders read it
  // (char at 1, palette at 3, gamma at 7) so beat order is kept
  typedef struct packed {
    logic v;
    logic [1:0] op;
    logic [16:0] a;
    logic [7:0] d;
  } wr_t;
  wr_t wr_pipe [1:7];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 7; k++) wr_pipe[k] <= '0;
    end else begin
      wr_pipe[1] <= {acc && (in_op != OP_RENDER), in_op, in_addr, in_data};
      for (int k = 2; k <= 7; k++) wr_pipe[k] <= wr_pipe[k-1];
    end
  end

  // stage 1: scroll, map address
  logic v1;
  logic [9:0] tx1, ty1;
  logic [9:0] sx, sy, txn, tyn;
  assign sx = 10'(scroll_x_word - 16'h035C);
  assign sy = scroll_y_word[9:0];
  assign txn = in_px + sx;
  assign tyn = 10'({1'b0, in_py} + sy);
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= acc && in_op == OP_RENDER && 32'(in_px) < SCREEN_WIDTH
               && 32'(in_py) < SCREEN_HEIGHT;
    tx1 <= txn; ty1 <= tyn;
  end

  logic [CAW-2:0] map_idx;
  assign map_idx = (CAW-1)'((CHAR_RAM_BYTES - 32'h2000) / 2
                   + 32'({ty1[9:4], tx1[9:4]}));

  // stage 2: tile word read
  logic v2;
  logic [9:0] tx2, ty2;
  logic [7:0] wh, wl;
  always_ff @(posedge clk) begin
    if (wr_pipe[1].v && wr_pipe[1].op == OP_CHAR && 32'(wr_pipe[1].a) < CHAR_RAM_BYTES) begin
      if (wr_pipe[1].a[0]) cram_o[wr_pipe[1].a[CAW-1:1]] <= wr_pipe[1].d;
      else cram_e[wr_pipe[1].a[CAW-1:1]] <= wr_pipe[1].d;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    tx2 <= tx1; ty2 <= ty1;
    wh <= cram_e[map_idx];
    wl <= cram_o[map_idx];
  end

  logic [15:0] w2;
  logic [3:0] cx2, cy2;
  logic [CAW-1:0] ch_addr;
  assign w2 = {wh, wl};
  assign cx2 = w2[10] ? 4'hF - tx2[3:0] : tx2[3:0];
  assign cy2 = w2[11] ? 4'hF - ty2[3:0] : ty2[3:0];
  assign ch_addr = CAW'({w2[9:0], cy2, cx2[3:1]});

  // stage 3: character byte read (banked by address bit 0)
  logic v3, odd3, nib3;
  logic [3:0] tpal3;
  logic [7:0] be3, bo3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    odd3 <= ch_addr[0]; nib3 <= cx2[0]; tpal3 <= w2[15:12];
    be3 <= cram_e[ch_addr[CAW-1:1]];
    bo3 <= cram_o[ch_addr[CAW-1:1]];
  end

  logic [7:0] byte3;
  logic [3:0] pix3;
  logic [14:0] pen3;
  assign byte3 = odd3 ? bo3 : be3;
  assign pix3 = nib3 ? byte3[3:0] : byte3[7:4];
  assign pen3 = {palette_base[6:0], tpal3, pix3};

  // stage 4: palette read
  logic v4, tr4;
  logic [7:0] p84;
  rgb_t c4;
  always_ff @(posedge clk) begin
    if (wr_pipe[3].v && wr_pipe[3].op == OP_PAL) begin
      if (wr_pipe[3].a[16:15] == 2'd0) pal_r[wr_pipe[3].a[14:0]] <= wr_pipe[3].d;
      if (wr_pipe[3].a[16:15] == 2'd1) pal_g[wr_pipe[3].a[14:0]] <= wr_pipe[3].d;
      if (wr_pipe[3].a[16:15] == 2'd2) pal_b[wr_pipe[3].a[14:0]] <= wr_pipe[3].d;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    tr4 <= pix3 == 4'hF; p84 <= pen3[7:0];
    c4[0] <= pal_r[pen3]; c4[1] <= pal_g[pen3]; c4[2] <= pal_b[pen3];
  end

  // stage 5: fade multiply
  logic v5, tr5, hit5;
  logic [15:0] fs5 [3];
  rgb_t c5;
  logic hitn;
  assign hitn = alpha_control[7:0] != 8'd0 &&
                (p84[3:0] == alpha_control[11:8] ||
                 (alpha_control[19:12] <= p84 && p84 <= alpha_control[27:20]));
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    tr5 <= tr4; hit5 <= hitn; c5 <= c4;
    for (int i = 0; i < 3; i++)
      fs5[i] <= mix_sum(c4[i], fade_colour[8*(2-i) +: 8], fade_factor);
  end

  // stage 6: fade divide
  logic v6, tr6, hit6;
  rgb_t c6;
  logic fade_on;
  assign fade_on = mode_flags[2] && fade_factor != 8'd0;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
    tr6 <= tr5; hit6 <= hit5;
    for (int i = 0; i < 3; i++) c6[i] <= fade_on ? div255(fs5[i]) : c5[i];
  end

  // background gamma is a table read in flight; gamma writes
  logic gam_we;
  logic [1:0] gam_ch;
  logic [7:0] gam_ix, gam_wd;
  assign gam_we = wr_pipe[7].v && wr_pipe[7].op == OP_GAMMA
                  && 32'(wr_pipe[7].a) < GAMMA_BYTES;
  assign gam_ch = wr_pipe[7].a[9:8];
  assign gam_ix = wr_pipe[7].a[7:0];
  assign gam_wd = wr_pipe[7].d;
  always_ff @(posedge clk) begin
    if (gam_we) begin
      if (gam_ch == 2'd0) gam_r[gam_ix] <= gam_wd;
      if (gam_ch == 2'd1) gam_g[gam_ix] <= gam_wd;
      if (gam_ch == 2'd2) gam_b[gam_ix] <= gam_wd;
    end
  end

  rgb_t bg_raw, bgc;
  assign bg_raw[0] = background_colour[23:16];
  assign bg_raw[1] = background_colour[15:8];
  assign bg_raw[2] = background_colour[7:0];

  // stage 7: blend multiply, background gamma read (forwarded from a same-cycle write)
  logic v7, tr7, hit7;
  logic [15:0] bs7 [3];
  rgb_t c7, bgg7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else v7 <= v6;
    tr7 <= tr6; hit7 <= hit6; c7 <= c6;
    bgg7[0] <= (gam_we && gam_ch == 2'd0 && gam_ix == bg_raw[0]) ? gam_wd : gam_r[bg_raw[0]];
    bgg7[1] <= (gam_we && gam_ch == 2'd1 && gam_ix == bg_raw[1]) ? gam_wd : gam_g[bg_raw[1]];
    bgg7[2] <= (gam_we && gam_ch == 2'd2 && gam_ix == bg_raw[2]) ? gam_wd : gam_b[bg_raw[2]];
  end
  assign bgc = mode_flags[1] ? bgg7 : bg_raw;

  // combinational gamma of background is taken from stage-7 read; blend sum
  always_comb begin
    for (int i = 0; i < 3; i++) bs7[i] = mix_sum(c7[i], bgc[i], alpha_control[7:0]);
  end

  // stage 8: blend sum registered
  logic v8, tr8, hit8;
  logic [15:0] bs8 [3];
  rgb_t c8, bg8;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else v8 <= v7;
    tr8 <= tr7; hit8 <= hit7; c8 <= c7; bg8 <= bgc;
    for (int i = 0; i < 3; i++) bs8[i] <= bs7[i];
  end

  rgb_t cb8;
  logic gate;
  assign gate = mode_flags[0];
  always_comb begin
    for (int i = 0; i < 3; i++) cb8[i] = (gate && hit8) ? div255(bs8[i]) : c8[i];
  end

  // stage 9: final gamma read
  logic v9, tr9, gg9;
  rgb_t c9, g9, bg9;
  logic [7:0] a9;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else v9 <= v8;
    tr9 <= tr8; c9 <= cb8; bg9 <= bg8;
    gg9 <= gate && mode_flags[1];
    a9 <= (!gate && hit8) ? 8'hFF - alpha_control[7:0] : 8'hFF;
    g9[0] <= gam_r[cb8[0]]; g9[1] <= gam_g[cb8[1]]; g9[2] <= gam_b[cb8[2]];
  end

  logic [31:0] res9;
  always_comb begin
    if (tr9) res9 = gate ? {8'hFF, bg9[2], bg9[1], bg9[0]} : 32'd0;
    else if (gg9) res9 = {a9, g9[2], g9[1], g9[0]};
    else res9 = {a9, c9[2], c9[1], c9[0]};
  end

  // output queue, deep enough for all beats in flight
  localparam int QD = 16;
  logic [31:0] q [QD];
  logic [3:0] wp, rp;
  logic [4:0] cnt;
  logic [3:0] inflight;
  logic pop;
  assign pop = m_tvalid && m_tready;
  assign m_tvalid = cnt != 5'd0;
  assign m_tdata = q[rp];
  assign inflight = 4'(v1) + 4'(v2) + 4'(v3) + 4'(v4) + 4'(v5) + 4'(v6) + 4'(v7)
                  + 4'(v8) + 4'(v9);
  assign s_tready = (5'(cnt) + 5'(inflight)) < 5'(QD - 1);
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (v9) wp <= wp + 4'd1;
      if (pop) rp <= rp + 4'd1;
      cnt <= cnt + 5'(v9) - 5'(pop);
    end
    if (v9) q[wp] <= res9;
  end
endmodule

@@ src/ttpr_checker.sv @@
// Port checker for the text tilemap pixel renderer.
// Depends on the top level's ports; bound by the statement below.
module ttpr_checker (
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [31:0] m_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output beat dropped");
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid) else $error("output right after reset");
  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> s_tready) else $error("input not ready after reset");
endmodule

bind text_tilemap_pixel_renderer ttpr_checker u_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ tb/text_tilemap_pixel_renderer_tb.sv @@
`timescale 1ns / 1ps
// Testbench for text_tilemap_pixel_renderer: drives memory writes and config phases; rendered pixels
// are checked against an in-bench pixel predictor. Depends on src/ttpr_pkg.sv and the RTL top.
module text_tilemap_pixel_renderer_tb;
  import ttpr_pkg::*;

  localparam int CHAR_BYTES = 131072;
  localparam int MAP_BASE = CHAR_BYTES - 8192;
  localparam int SCR_W = 640;
  localparam int SCR_H = 480;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [27:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;

  text_tilemap_pixel_renderer dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow memories, with written flags for char and palette
  logic [7:0] char_mem [CHAR_BYTES];
  bit char_set [CHAR_BYTES];
  logic [7:0] pal_mem [3 * PLANE_BYTES];
  bit pal_set [3 * PLANE_BYTES];
  logic [7:0] gamma_mem [GAMMA_BYTES];

  logic [15:0] scroll_x, scroll_y;
  logic [7:0] pal_base, fade_f;
  logic [23:0] fade_c, bg_c;
  logic [27:0] alpha_ctl;
  logic [2:0] mode;

  pixel_t pixel_q[$];
  int errors = 0;
  int n_render = 0, n_write = 0, n_pixels = 0;
  int cycles = 0;
  int hold_req = 0;
  int hold_done = 0;

  function automatic int blend(int c, int t, int f);
    return (c * (255 - f) + t * f) / 255;
  endfunction

  function automatic pixel_t shade(int x, int y);
    int sx, sy, tx, ty, ti, w, code, tpal, cx, cy, cb, pix, pen, p8;
    int af, am, lo, hi;
    int c[3], bg[3], fc[3];
    pixel_t o;
    for (int i = 0; i < 3; i++) begin
      bg[i] = (bg_c >> (16 - 8 * i)) & 8'hFF;
      fc[i] = (fade_c >> (16 - 8 * i)) & 8'hFF;
      if (mode[1]) bg[i] = gamma_mem[i * 256 + bg[i]];
    end
    sx = (int'(scroll_x) - 'h35C) & 'h3FF;
    sy = scroll_y & 'h3FF;
    tx = (x + sx) & 'h3FF;
    ty = (y + sy) & 'h3FF;
    ti = MAP_BASE + ((ty >> 4) * 64 + (tx >> 4)) * 2;
    w = {char_mem[ti], char_mem[ti + 1]};
    code = w & 'h3FF;
    tpal = (w >> 12) & 'hF;
    cx = tx & 15;
    cy = ty & 15;
    if (w & 'h400) cx = 15 - cx;
    if (w & 'h800) cy = 15 - cy;
    cb = char_mem[(code * 128 + cy * 8 + (cx >> 1)) % CHAR_BYTES];
    pix = (cx & 1) ? (cb & 'hF) : (cb >> 4);
    if (pix == 15) begin
      if (mode[0]) return '{8'(bg[0]), 8'(bg[1]), 8'(bg[2]), 8'd255};
      return '0;
    end
    pen = (((pal_base << 8) & 'h7F00) | (tpal << 4) | pix) & 'h7FFF;
    for (int i = 0; i < 3; i++) c[i] = pal_mem[pen + i * PLANE_BYTES];
    if (mode[2] && fade_f != 0)
      for (int i = 0; i < 3; i++) c[i] = blend(c[i], fc[i], fade_f);
    af = alpha_ctl[7:0];
    am = alpha_ctl[11:8];
    lo = alpha_ctl[19:12];
    hi = alpha_ctl[27:20];
    p8 = pen & 'hFF;
    o.alpha = 8'd255;
    if (af != 0 && ((p8 & 'hF) == am || (lo <= p8 && p8 <= hi))) begin
      if (mode[0]) for (int i = 0; i < 3; i++) c[i] = blend(c[i], bg[i], af);
      else o.alpha = 8'(255 - af);
    end
    if (mode[0] && mode[1]) for (int i = 0; i < 3; i++) c[i] = gamma_mem[i * 256 + c[i]];
    o.red = 8'(c[0]);
    o.green = 8'(c[1]);
    o.blue = 8'(c[2]);
    return o;
  endfunction

  // one beat; the shadow state is updated in beat order once accepted
  task automatic send_beat(logic [1:0] op, logic [16:0] addr, logic [7:0] data,
                           logic [9:0] x, logic [8:0] y);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {2'b0, y, x, data, addr, op};
    do @(posedge clk); while (!s_tready);
    case (op)
      OP_CHAR: begin
        char_mem[addr] = data;
        char_set[addr] = 1'b1;
        n_write++;
      end
      OP_PAL: begin
        if (addr < 3 * PLANE_BYTES) begin
          pal_mem[addr] = data;
          pal_set[addr] = 1'b1;
        end
        n_write++;
      end
      OP_GAMMA: begin
        if (addr < GAMMA_BYTES) gamma_mem[addr] = data;
        n_write++;
      end
      default: begin
        n_render++;
        if (x < SCR_W && y < SCR_H) pixel_q.push_back(shade(x, y));
      end
    endcase
  endtask

  task automatic fill_char(int a);
    if (!char_set[a]) send_beat(OP_CHAR, 17'(a), 8'($urandom), '0, '0);
  endtask

  task automatic fill_pal(int a);
    if (!pal_set[a]) send_beat(OP_PAL, 17'(a), 8'($urandom), '0, '0);
  endtask

  // render an on-screen pixel, first writing any unwritten char or palette byte it would read
  task automatic render(int x, int y);
    int sx, sy, tx, ty, ti, w, cx, cy, ca, pix, pen;
    sx = (int'(scroll_x) - 'h35C) & 'h3FF;
    sy = scroll_y & 'h3FF;
    tx = (x + sx) & 'h3FF;
    ty = (y + sy) & 'h3FF;
    ti = MAP_BASE + ((ty >> 4) * 64 + (tx >> 4)) * 2;
    fill_char(ti);
    fill_char(ti + 1);
    w = {char_mem[ti], char_mem[ti + 1]};
    cx = (w & 'h400) ? 15 - (tx & 15) : tx & 15;
    cy = (w & 'h800) ? 15 - (ty & 15) : ty & 15;
    ca = ((w & 'h3FF) * 128 + cy * 8 + (cx >> 1)) % CHAR_BYTES;
    fill_char(ca);
    pix = (cx & 1) ? (char_mem[ca] & 'hF) : (char_mem[ca] >> 4);
    if (pix != 15) begin
      pen = (((pal_base << 8) & 'h7F00) | (((w >> 12) & 'hF) << 4) | pix) & 'h7FFF;
      for (int i = 0; i < 3; i++) fill_pal(pen + i * PLANE_BYTES);
    end
    send_beat(OP_RENDER, 17'($urandom), 8'($urandom), 10'(x), 9'(y));
  endtask

  task automatic drain();
    @(negedge clk) s_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [27:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      REG_SCROLL_X: scroll_x = val[15:0];
      REG_SCROLL_Y: scroll_y = val[15:0];
      REG_PAL_BASE: pal_base = val[7:0];
      REG_FADE_F: fade_f = val[7:0];
      REG_FADE_C: fade_c = val[23:0];
      REG_ALPHA: alpha_ctl = val;
      REG_MODE: mode = val[2:0];
      default: bg_c = val[23:0];
    endcase
  endtask

  task automatic set_regs(logic [15:0] sx, logic [15:0] sy, logic [7:0] pb, logic [7:0] ff,
                          logic [23:0] fc, logic [27:0] ac, logic [2:0] md, logic [23:0] bg);
    drain();
    write_reg(REG_SCROLL_X, 28'(sx));
    write_reg(REG_SCROLL_Y, 28'(sy));
    write_reg(REG_PAL_BASE, 28'(pb));
    write_reg(REG_FADE_F, 28'(ff));
    write_reg(REG_FADE_C, 28'(fc));
    write_reg(REG_ALPHA, ac);
    write_reg(REG_MODE, 28'(md));
    write_reg(REG_BG, 28'(bg));
  endtask

  task automatic test_gamma_load();
    for (int i = 0; i < GAMMA_BYTES; i++) send_beat(OP_GAMMA, 17'(i), 8'($urandom), '0, '0);
  endtask

  task automatic test_directed();
    int tile;
    send_beat(OP_GAMMA, 17'(GAMMA_BYTES), 8'hFF, '0, '0);
    send_beat(OP_GAMMA, 17'h1FFFF, 8'h00, '0, '0);
    send_beat(OP_PAL, 17'(3 * PLANE_BYTES), 8'hFF, '0, '0);
    send_beat(OP_PAL, 17'h1FFFF, 8'h00, '0, '0);
    send_beat(OP_CHAR, 17'h1FFFF, 8'hFF, '0, '0);
    send_beat(OP_CHAR, 17'h00000, 8'h00, '0, '0);
    // tile under pixel (0,0) with scroll 0: code 0, both flips
    tile = MAP_BASE + ((0 >> 4) * 64 + (('h400 - 'h35C) >> 4)) * 2;
    send_beat(OP_CHAR, 17'(tile), 8'h0C, '0, '0);
    send_beat(OP_CHAR, 17'(tile + 1), 8'h00, '0, '0);
    for (int i = 0; i < 128; i += 37) send_beat(OP_CHAR, 17'(i), 8'hFF, '0, '0);
    render(0, 0);
    render(SCR_W - 1, SCR_H - 1);
    render(SCR_W - 1, 0);
    render(0, SCR_H - 1);
    send_beat(OP_RENDER, '0, '0, 10'd640, 9'd0);
    send_beat(OP_RENDER, '0, '0, 10'd0, 9'd480);
    send_beat(OP_RENDER, 17'h1FFFF, 8'hFF, 10'h3FF, 9'h1FF);
  endtask

  task automatic random_items(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 70) render($urandom_range(0, SCR_W - 1), $urandom_range(0, SCR_H - 1));
      else if (k < 78)
        send_beat(OP_RENDER, 17'($urandom), 8'($urandom), 10'($urandom_range(640, 1023)),
                  9'($urandom));
      else if (k < 88) send_beat(OP_CHAR, 17'($urandom), 8'($urandom), '0, '0);
      else if (k < 96) send_beat(OP_PAL, 17'($urandom), 8'($urandom), '0, '0);
      else send_beat(OP_GAMMA, 17'($urandom_range(0, 1023)), 8'($urandom), '0, '0);
    end
  endtask

  task automatic test_config_phases();
    logic [7:0] lo, hi;
    set_regs('0, '0, '0, '0, '0, '0, '0, '0);
    random_items(30);
    set_regs(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 24'hFFFFFF, 28'hFFFFFFF, 3'd7, 24'hFFFFFF);
    random_items(30);
    for (int p = 0; p < 6; p++) begin
      lo = 8'($urandom);
      hi = lo + 8'($urandom_range(0, 60));
      set_regs(16'($urandom), 16'($urandom), 8'($urandom), (p == 2) ? 8'd0 : 8'($urandom),
               24'($urandom), {hi, lo, 4'($urandom), (p == 3) ? 8'd0 : 8'($urandom)},
               3'(p), 24'($urandom));
      random_items(15);
    end
  endtask

  task automatic test_backpressure();
    set_regs(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 24'($urandom),
             28'($urandom), 3'd6, 24'($urandom));
    hold_req++;
    for (int i = 0; i < 24; i++) render($urandom_range(0, 63), $urandom_range(0, 15));
    drain();
    random_items(20);
  endtask

  // receiver: a random wait before each beat, and a long hold when requested
  initial begin
    int wait_n;
    forever begin
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      wait_n = $urandom_range(0, 4);
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    pixel_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]};
      n_pixels++;
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel beat %h", m_tdata);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (got.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red);
          errors++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green);
          errors++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue);
          errors++;
        end
        if (got.alpha !== want.alpha) begin
          $error("alpha: expected %0d, got %0d", want.alpha, got.alpha);
          errors++;
        end
      end
    end
  end

  initial begin
    {scroll_x, scroll_y, pal_base, fade_f, fade_c, alpha_ctl, mode, bg_c} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_gamma_load();
    test_directed();
    test_config_phases();
    test_backpressure();
    drain();
    if (pixel_q.size() != 0) begin
      $error("%0d pixels never arrived", pixel_q.size());
      errors++;
    end
    $display("covered %0d render beats, %0d memory writes, %0d pixels checked",
             n_render, n_write, n_pixels);
    $display("across zero, full-scale and random register settings, with stalls");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
